>>> rtl/qte_pkg.sv
// Shared types and constants for the quaternion to Euler angle converter.
package qte_pkg;

    localparam int QIN_W   = 16;          // input component width, Q2.14
    localparam int P_W     = 32;          // one product of two components
    localparam int ARG_W   = 34;          // sums of products and atan2 arguments
    localparam int N_W     = 33;          // squared norm, unsigned
    localparam int Q_W     = 30;          // magnitude of the pitch sine, Q0.30
    localparam int ROOT_W  = 31;          // pitch cosine, up to 2^30
    localparam int SQ_W    = 62;          // square root remainder
    localparam int CW      = 56;          // CORDIC vector registers
    localparam int ACC_W   = 26;          // CORDIC angle, degrees * 2^16
    localparam int PRE_SH  = 20;          // CORDIC operand prescale
    localparam int ROLL_W  = 16;
    localparam int PITCH_W = 15;

    localparam int DIV_LAT  = Q_W;
    localparam int SQRT_LAT = ROOT_W + 1;

    localparam logic signed [ACC_W-1:0] ANG_MAX_ROLL  = 26'sd23040;
    localparam logic signed [ACC_W-1:0] ANG_MAX_PITCH = 26'sd11520;
    localparam logic signed [ACC_W-1:0] DEG90         = 26'sd5898240;

    // atan(2^-i) in degrees * 2^16, rounded.
    localparam logic signed [ACC_W-1:0] ATAN_TAB [32] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
        26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
        26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
        26'sd917,     26'sd458,     26'sd229,    26'sd115,
        26'sd57,      26'sd29,      26'sd14,     26'sd7,
        26'sd4,       26'sd2,       26'sd1,      26'sd0,
        26'sd0,       26'sd0,       26'sd0,      26'sd0,
        26'sd0,       26'sd0,       26'sd0,      26'sd0
    };

    typedef struct packed {
        logic signed [ARG_W-1:0] roll_y;
        logic signed [ARG_W-1:0] roll_x;
        logic signed [ARG_W-1:0] yaw_y;
        logic signed [ARG_W-1:0] yaw_x;
    } t_args;

    typedef struct packed {
        logic degen;
        logic sat_pos;
        logic sat_neg;
    } t_flags;

endpackage

>>> rtl/qte_in_if.sv
// Input channel carrying one quaternion word.
interface qte_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [qte_pkg::QIN_W-1:0]    quat_w;
    logic signed [qte_pkg::QIN_W-1:0]    quat_x;
    logic signed [qte_pkg::QIN_W-1:0]    quat_y;
    logic signed [qte_pkg::QIN_W-1:0]    quat_z;

    modport source(output valid, output quat_w, output quat_x, output quat_y,
                   output quat_z, input ready);
    modport sink(input valid, input quat_w, input quat_x, input quat_y,
                 input quat_z, output ready);
endinterface

>>> rtl/qte_out_if.sv
// Output channel carrying one word of Euler angles.
interface qte_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [qte_pkg::ROLL_W-1:0]    roll_angle;
    logic signed [qte_pkg::PITCH_W-1:0]   pitch_angle;
    logic signed [qte_pkg::ROLL_W-1:0]    yaw_angle;
    logic                                 degenerate;

    modport source(output valid, output roll_angle, output pitch_angle,
                   output yaw_angle, output degenerate, input ready);
    modport sink(input valid, input roll_angle, input pitch_angle,
                 input yaw_angle, input degenerate, output ready);
endinterface

>>> rtl/qte_prod.sv
// Products, sums and pitch range flags in three pipeline stages.
module qte_prod (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_vld,
    input  logic signed [qte_pkg::QIN_W-1:0]      i_w,
    input  logic signed [qte_pkg::QIN_W-1:0]      i_x,
    input  logic signed [qte_pkg::QIN_W-1:0]      i_y,
    input  logic signed [qte_pkg::QIN_W-1:0]      i_z,
    output logic                                  o_vld,
    output logic [qte_pkg::N_W-1:0]               o_n,
    output logic [qte_pkg::ARG_W-1:0]             o_abs_num,
    output logic                                  o_neg,
    output qte_pkg::t_args                        o_args,
    output qte_pkg::t_flags                       o_flags
);
    localparam int PW = qte_pkg::P_W;
    localparam int AW = qte_pkg::ARG_W;

    logic signed [PW-1:0] r_ww, r_xx, r_yy, r_zz, r_wx, r_yz, r_wz, r_xy, r_wy, r_zx;
    logic signed [AW-1:0] r_n, r_num;
    logic signed [AW-1:0] n_n, n_num;
    qte_pkg::t_args       r_args2, n_args2;
    logic                 r_vld1, r_vld2, r_vld3;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ww <= PW'(i_w) * PW'(i_w);
            r_xx <= PW'(i_x) * PW'(i_x);
            r_yy <= PW'(i_y) * PW'(i_y);
            r_zz <= PW'(i_z) * PW'(i_z);
            r_wx <= PW'(i_w) * PW'(i_x);
            r_yz <= PW'(i_y) * PW'(i_z);
            r_wz <= PW'(i_w) * PW'(i_z);
            r_xy <= PW'(i_x) * PW'(i_y);
            r_wy <= PW'(i_w) * PW'(i_y);
            r_zx <= PW'(i_z) * PW'(i_x);
        end
    end

    always_comb begin
        n_n = AW'(r_ww) + AW'(r_xx) + AW'(r_yy) + AW'(r_zz);
        n_num = (AW'(r_wy) - AW'(r_zx)) <<< 1;
        n_args2.roll_y = (AW'(r_wx) + AW'(r_yz)) <<< 1;
        n_args2.roll_x = n_n - ((AW'(r_xx) + AW'(r_yy)) <<< 1);
        n_args2.yaw_y  = (AW'(r_wz) + AW'(r_xy)) <<< 1;
        n_args2.yaw_x  = n_n - ((AW'(r_yy) + AW'(r_zz)) <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n     <= n_n;
            r_num   <= n_num;
            r_args2 <= n_args2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_n             <= r_n[qte_pkg::N_W-1:0];
            o_abs_num       <= r_num[AW-1] ? AW'(-r_num) : AW'(r_num);
            o_neg           <= r_num[AW-1];
            o_args          <= r_args2;
            o_flags.degen   <= (r_n == '0);
            o_flags.sat_pos <= (r_num >= r_n);
            o_flags.sat_neg <= ((-r_num) >= r_n);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
        end
    end

    assign o_vld = r_vld3;
endmodule

>>> rtl/qte_div.sv
// Pipelined restoring divider, one quotient bit of the pitch sine per stage.
module qte_div (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_vld,
    input  logic [qte_pkg::N_W-1:0]               i_n,
    input  logic [qte_pkg::ARG_W-1:0]             i_abs_num,
    input  logic                                  i_neg,
    output logic                                  o_vld,
    output logic [qte_pkg::Q_W-1:0]               o_q,
    output logic                                  o_neg
);
    localparam int QW = qte_pkg::Q_W;
    localparam int NW = qte_pkg::N_W;
    localparam int RW = qte_pkg::ARG_W;

    logic [RW-1:0] r_rem [1:QW];
    logic [QW-1:0] r_quo [1:QW];
    logic [NW-1:0] r_n   [1:QW];
    logic          r_neg [1:QW];
    logic          r_vld [1:QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [RW-1:0] rem_in, rem2;
        logic [QW-1:0] quo_in;
        logic [NW-1:0] n_in;
        logic          neg_in, vld_in, ge;

        if (k == 0) begin : g_first
            assign rem_in = i_abs_num;
            assign quo_in = '0;
            assign n_in   = i_n;
            assign neg_in = i_neg;
            assign vld_in = i_vld;
        end else begin : g_next
            assign rem_in = r_rem[k];
            assign quo_in = r_quo[k];
            assign n_in   = r_n[k];
            assign neg_in = r_neg[k];
            assign vld_in = r_vld[k];
        end

        assign rem2 = {rem_in[RW-2:0], 1'b0};
        assign ge   = (rem2 >= {1'b0, n_in});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= ge ? (rem2 - {1'b0, n_in}) : rem2;
                r_quo[k+1] <= {quo_in[QW-2:0], ge};
                r_n[k+1]   <= n_in;
                r_neg[k+1] <= neg_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= vld_in;
            end
        end
    end

    assign o_vld = r_vld[QW];
    assign o_q   = r_quo[QW];
    assign o_neg = r_neg[QW];
endmodule

>>> rtl/qte_sqrt.sv
// Pitch cosine: one squaring stage, then a pipelined integer square root.
module qte_sqrt (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_vld,
    input  logic [qte_pkg::Q_W-1:0]               i_q,
    input  logic                                  i_neg,
    output logic                                  o_vld,
    output logic [qte_pkg::Q_W-1:0]               o_q,
    output logic                                  o_neg,
    output logic [qte_pkg::ROOT_W-1:0]            o_root
);
    localparam int QW = qte_pkg::Q_W;
    localparam int RT = qte_pkg::ROOT_W;
    localparam int SW = qte_pkg::SQ_W;

    logic [2*QW-1:0] w_sq;
    logic [SW-1:0]   r_c2;
    logic [QW-1:0]   r_q0;
    logic            r_neg0, r_vld0;

    logic [SW-1:0]   r_rem  [1:RT];
    logic [RT-1:0]   r_root [1:RT];
    logic [QW-1:0]   r_q    [1:RT];
    logic            r_neg  [1:RT];
    logic            r_vld  [1:RT];

    // cos^2 = 1 - sin^2 in Q0.60.
    assign w_sq = (2*QW)'(i_q) * (2*QW)'(i_q);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c2   <= (SW'(1) << (2*QW)) - SW'(w_sq);
            r_q0   <= i_q;
            r_neg0 <= i_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else if (i_en) begin
            r_vld0 <= i_vld;
        end
    end

    for (genvar k = 0; k < RT; k++) begin : g_step
        localparam int B = RT - 1 - k;
        logic [SW-1:0] rem_in, trial;
        logic [RT-1:0] root_in;
        logic [QW-1:0] q_in;
        logic          neg_in, vld_in, ge;

        if (k == 0) begin : g_first
            assign rem_in  = r_c2;
            assign root_in = '0;
            assign q_in    = r_q0;
            assign neg_in  = r_neg0;
            assign vld_in  = r_vld0;
        end else begin : g_next
            assign rem_in  = r_rem[k];
            assign root_in = r_root[k];
            assign q_in    = r_q[k];
            assign neg_in  = r_neg[k];
            assign vld_in  = r_vld[k];
        end

        // (root + 2^B)^2 - root^2; root holds only bits above B here.
        assign trial = (SW'(root_in) << (B + 1)) | (SW'(1) << (2 * B));
        assign ge    = (rem_in >= trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= ge ? (rem_in - trial) : rem_in;
                r_root[k+1] <= ge ? (root_in | (RT'(1) << B)) : root_in;
                r_q[k+1]    <= q_in;
                r_neg[k+1]  <= neg_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= vld_in;
            end
        end
    end

    assign o_vld  = r_vld[RT];
    assign o_q    = r_q[RT];
    assign o_neg  = r_neg[RT];
    assign o_root = r_root[RT];
endmodule

>>> rtl/qte_cordic.sv
// Pipelined CORDIC in vectoring mode: one quadrant stage, then one stage per iteration.
module qte_cordic #(
    parameter int ITER = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_vld,
    input  logic signed [qte_pkg::ARG_W-1:0]      i_y,
    input  logic signed [qte_pkg::ARG_W-1:0]      i_x,
    output logic                                  o_vld,
    output logic                                  o_zero,
    output logic signed [qte_pkg::ACC_W-1:0]      o_acc
);
    localparam int CW = qte_pkg::CW;
    localparam int AW = qte_pkg::ACC_W;

    logic signed [CW-1:0] w_ye, w_xe;
    logic signed [CW-1:0] r_x0, r_y0;
    logic signed [AW-1:0] r_acc0;
    logic                 r_zero0, r_vld0;

    logic signed [CW-1:0] r_x    [1:ITER];
    logic signed [CW-1:0] r_y    [1:ITER];
    logic signed [AW-1:0] r_acc  [1:ITER];
    logic                 r_zero [1:ITER];
    logic                 r_vld  [1:ITER];

    assign w_ye = CW'(i_y) <<< qte_pkg::PRE_SH;
    assign w_xe = CW'(i_x) <<< qte_pkg::PRE_SH;

    // A vector in the left half plane is first turned by 90 degrees.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero0 <= (i_x == '0) && (i_y == '0);
            if (!w_xe[CW-1]) begin
                r_x0   <= w_xe;
                r_y0   <= w_ye;
                r_acc0 <= '0;
            end else if (!w_ye[CW-1]) begin
                r_x0   <= w_ye;
                r_y0   <= -w_xe;
                r_acc0 <= qte_pkg::DEG90;
            end else begin
                r_x0   <= -w_ye;
                r_y0   <= w_xe;
                r_acc0 <= -qte_pkg::DEG90;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else if (i_en) begin
            r_vld0 <= i_vld;
        end
    end

    for (genvar i = 0; i < ITER; i++) begin : g_iter
        logic signed [CW-1:0] x_in, y_in, xs, ys;
        logic signed [AW-1:0] acc_in;
        logic                 zero_in, vld_in;

        if (i == 0) begin : g_first
            assign x_in    = r_x0;
            assign y_in    = r_y0;
            assign acc_in  = r_acc0;
            assign zero_in = r_zero0;
            assign vld_in  = r_vld0;
        end else begin : g_next
            assign x_in    = r_x[i];
            assign y_in    = r_y[i];
            assign acc_in  = r_acc[i];
            assign zero_in = r_zero[i];
            assign vld_in  = r_vld[i];
        end

        assign xs = x_in >>> i;
        assign ys = y_in >>> i;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!y_in[CW-1]) begin
                    r_x[i+1]   <= x_in + ys;
                    r_y[i+1]   <= y_in - xs;
                    r_acc[i+1] <= acc_in + qte_pkg::ATAN_TAB[i];
                end else begin
                    r_x[i+1]   <= x_in - ys;
                    r_y[i+1]   <= y_in + xs;
                    r_acc[i+1] <= acc_in - qte_pkg::ATAN_TAB[i];
                end
                r_zero[i+1] <= zero_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[i+1] <= vld_in;
            end
        end
    end

    assign o_vld  = r_vld[ITER];
    assign o_zero = r_zero[ITER];
    assign o_acc  = r_acc[ITER];
endmodule

>>> rtl/quaternion_to_euler_angles.sv
// Throughput: one word per cycle; the pipeline advances whenever the output register is free.
// The pitch divider (30 stages) and cosine square root (32 stages) set most of the depth.
// Reset (i_rst_n, synchronous, active low) clears every valid bit; data registers keep garbage.
// After reset the block takes a word in the very next cycle.
module quaternion_to_euler_angles #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    qte_in_if.sink         i_quat,
    qte_out_if.source      o_euler
);
    localparam int AW  = qte_pkg::ARG_W;
    localparam int CA  = qte_pkg::ACC_W;
    localparam int RT  = qte_pkg::ROOT_W;
    localparam int DLY = qte_pkg::DIV_LAT + qte_pkg::SQRT_LAT;
    localparam int FD  = DLY + CORDIC_ITERATIONS + 1;

    // The whole pipeline moves together. It stalls only while a finished word sits in
    // the output register and the sink refuses it, so no word is ever dropped or copied.
    logic en;

    logic                       prod_vld, prod_neg;
    logic [qte_pkg::N_W-1:0]    prod_n;
    logic [AW-1:0]              prod_abs;
    qte_pkg::t_args             prod_args;
    qte_pkg::t_flags            prod_flags;

    logic                       div_vld, div_neg;
    logic [qte_pkg::Q_W-1:0]    div_q;

    logic                       sq_vld, sq_neg;
    logic [qte_pkg::Q_W-1:0]    sq_q;
    logic [RT-1:0]              sq_root;
    logic signed [RT-1:0]       w_s;
    logic signed [AW-1:0]       w_pitch_y, w_pitch_x;

    // Roll and yaw arguments wait here while the pitch sine and cosine are formed.
    qte_pkg::t_args             r_args  [DLY];
    qte_pkg::t_flags            r_flags [FD];

    logic                       cr_zero, cy_zero, cp_zero, cp_vld;
    logic signed [CA-1:0]       cr_acc, cy_acc, cp_acc;

    logic signed [qte_pkg::ROLL_W-1:0]  r_roll, n_roll;
    logic signed [qte_pkg::PITCH_W-1:0] r_pitch, n_pitch;
    logic signed [qte_pkg::ROLL_W-1:0]  r_yaw, n_yaw;
    logic                               r_degen, n_degen;
    logic                               r_out_vld;

    assign en           = !r_out_vld || o_euler.ready;
    assign i_quat.ready = en;

    // Stages 1 to 3: component products, then the norm and the atan2 arguments,
    // then the pitch range flags and the magnitude of the pitch numerator.
    qte_prod u_prod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_vld     (i_quat.valid),
        .i_w       (i_quat.quat_w),
        .i_x       (i_quat.quat_x),
        .i_y       (i_quat.quat_y),
        .i_z       (i_quat.quat_z),
        .o_vld     (prod_vld),
        .o_n       (prod_n),
        .o_abs_num (prod_abs),
        .o_neg     (prod_neg),
        .o_args    (prod_args),
        .o_flags   (prod_flags)
    );

    // Pitch sine magnitude: |2(wy - zx)| * 2^30 / n, one bit per stage.
    // When the numerator reaches the norm the quotient is meaningless, and the
    // saturation flags pick the pitch instead.
    qte_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_vld     (prod_vld),
        .i_n       (prod_n),
        .i_abs_num (prod_abs),
        .i_neg     (prod_neg),
        .o_vld     (div_vld),
        .o_q       (div_q),
        .o_neg     (div_neg)
    );

    // Pitch cosine: floor(sqrt(2^60 - s^2)).
    qte_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (div_vld),
        .i_q     (div_q),
        .i_neg   (div_neg),
        .o_vld   (sq_vld),
        .o_q     (sq_q),
        .o_neg   (sq_neg),
        .o_root  (sq_root)
    );

    // The sine gets back the sign of the numerator; division truncated toward zero.
    assign w_s       = sq_neg ? -$signed({1'b0, sq_q}) : $signed({1'b0, sq_q});
    assign w_pitch_y = AW'(w_s);
    assign w_pitch_x = $signed({{(AW - RT){1'b0}}, sq_root});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_args[0]  <= prod_args;
            r_flags[0] <= prod_flags;
            for (int k = 1; k < DLY; k++) begin
                r_args[k] <= r_args[k-1];
            end
            for (int k = 1; k < FD; k++) begin
                r_flags[k] <= r_flags[k-1];
            end
        end
    end

    // Three CORDIC units run side by side on the same word.
    qte_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (sq_vld),
        .i_y     (r_args[DLY-1].roll_y),
        .i_x     (r_args[DLY-1].roll_x),
        .o_vld   (),
        .o_zero  (cr_zero),
        .o_acc   (cr_acc)
    );

    qte_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (sq_vld),
        .i_y     (r_args[DLY-1].yaw_y),
        .i_x     (r_args[DLY-1].yaw_x),
        .o_vld   (),
        .o_zero  (cy_zero),
        .o_acc   (cy_acc)
    );

    qte_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (sq_vld),
        .i_y     (w_pitch_y),
        .i_x     (w_pitch_x),
        .o_vld   (cp_vld),
        .o_zero  (cp_zero),
        .o_acc   (cp_acc)
    );

    // Rounds degrees * 2^16 half up to 1/128 degree and clamps to the given limit.
    // A zero atan2 argument gives an angle of zero.
    function automatic logic signed [CA-1:0] round_clamp(
        input logic signed [CA-1:0] acc,
        input logic                 zero,
        input logic signed [CA-1:0] lim
    );
        logic signed [CA-1:0] v;
        v = (acc + CA'(256)) >>> 9;
        if (zero) begin
            v = '0;
        end else if (v > lim) begin
            v = lim;
        end else if (v < -lim) begin
            v = -lim;
        end
        return v;
    endfunction

    // Output stage. A zero quaternion forces all angles to zero; a sine at or
    // beyond one pins pitch to plus or minus 90 degrees.
    always_comb begin
        logic signed [CA-1:0] roll_v, yaw_v, pitch_v;
        qte_pkg::t_flags      f;
        f       = r_flags[FD-1];
        roll_v  = round_clamp(cr_acc, cr_zero, qte_pkg::ANG_MAX_ROLL);
        yaw_v   = round_clamp(cy_acc, cy_zero, qte_pkg::ANG_MAX_ROLL);
        pitch_v = round_clamp(cp_acc, cp_zero, qte_pkg::ANG_MAX_PITCH);
        if (f.sat_pos) begin
            pitch_v = qte_pkg::ANG_MAX_PITCH;
        end else if (f.sat_neg) begin
            pitch_v = -qte_pkg::ANG_MAX_PITCH;
        end
        if (f.degen) begin
            roll_v  = '0;
            yaw_v   = '0;
            pitch_v = '0;
        end
        n_roll  = roll_v[qte_pkg::ROLL_W-1:0];
        n_yaw   = yaw_v[qte_pkg::ROLL_W-1:0];
        n_pitch = pitch_v[qte_pkg::PITCH_W-1:0];
        n_degen = f.degen;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_roll  <= n_roll;
            r_pitch <= n_pitch;
            r_yaw   <= n_yaw;
            r_degen <= n_degen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= cp_vld;
        end
    end

    assign o_euler.valid       = r_out_vld;
    assign o_euler.roll_angle  = r_roll;
    assign o_euler.pitch_angle = r_pitch;
    assign o_euler.yaw_angle   = r_yaw;
    assign o_euler.degenerate  = r_degen;
endmodule
